// ----- rtl/core/sbfr_pkg.sv -----
package sbfr_pkg;

	localparam int BANDS_DEF = 32;
	localparam int ROWS_DEF  = 32;
	localparam int ROWS_MAX  = 64;

	localparam int COL_W   = 5;
	localparam int LEVEL_W = 16;
	localparam int DT_W    = 16;
	localparam int ACC_W   = 16;
	localparam int HUE_W   = 16;
	localparam int PIX_W   = 8;

	// lit count never exceeds ROWS-1
	localparam int LIT_W = $clog2(ROWS_MAX);

	localparam logic [ACC_W-1:0] FALL_ACCEL_RST = 16'd1;
	localparam logic [PIX_W-1:0] PIX_FULL       = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_DARK       = 8'h00;

	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [LIT_W-1:0] lit;
		logic             frame_start;
	} col_job_t;

	// c mod 255: 2^8 == 1 (mod 255), so hi + lo, then at most two subtracts
	function automatic logic [PIX_W-1:0] hue_mod(input logic [HUE_W-1:0] c);
		logic [8:0] m;
		m = {1'b0, c[15:8]} + {1'b0, c[7:0]};
		if (m >= 9'd255) begin
			m = m - 9'd255;
		end
		if (m >= 9'd255) begin
			m = m - 9'd255;
		end
		return m[7:0];
	endfunction

endpackage

// ----- rtl/core/sbfr_front.sv -----
module sbfr_front
	import sbfr_pkg::*;
#(
	parameter int BANDS = BANDS_DEF,
	parameter int ROWS  = ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ACC_W-1:0]   fall_accel,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COL_W-1:0]   band,
	input  logic [LEVEL_W-1:0] level,
	input  logic [DT_W-1:0]    step_time,
	input  logic               frame_start,
	output logic               push_valid,
	input  logic               push_ready,
	output col_job_t           push_data
);

	localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_VEL  = 3'd2;
	localparam logic [2:0] S_POS  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;
	localparam logic [2:0] S_LIT  = 3'd5;

	logic [2:0]         state_q;
	logic [COL_W-1:0]   band_q;
	logic [BW-1:0]      addr_q;
	logic [LEVEL_W-1:0] level_q;
	logic [DT_W-1:0]    dt_q;
	logic               fs_q;
	logic [31:0]        h_q;
	logic [31:0]        v_q;
	logic [15:0]        dv_q;
	logic [31:0]        step_q;
	logic [BANDS-1:0]   valid_q;

	// band state: {height, velocity}
	logic [63:0] mem [BANDS];
	logic [63:0] rdata_s1;

	logic               accept;
	logic               in_range;
	logic [BW+COL_W-1:0] band_ext;
	logic [BW-1:0]      rd_addr;
	logic               mem_we;
	logic [63:0]        mem_wdata;
	logic [31:0]        dv_prod;
	logic [32:0]        vdiff;
	logic [31:0]        vsat;
	logic [48:0]        vstep_prod;
	logic signed [33:0] hsum;
	logic signed [33:0] lev;
	logic signed [33:0] hsel;
	logic [31:0]        vsel;
	logic [31:0]        hnew;
	logic [31:0]        vnew;
	logic [37:0]        h60;
	logic [9:0]         lit_raw;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = ({2'b00, band} < 7'(BANDS));
	assign band_ext = (BW + COL_W)'(band);
	assign rd_addr  = band_ext[BW-1:0];

	assign dv_prod = fall_accel * dt_q;

	always_comb begin
		vdiff = {v_q[31], v_q} - {17'b0, dv_q};
		if (vdiff[32] != vdiff[31]) begin
			vsat = 32'h8000_0000;
		end else begin
			vsat = vdiff[31:0];
		end
	end

	assign vstep_prod = $signed(v_q) * $signed({1'b0, dt_q});

	always_comb begin
		hsum = $signed({2'b00, h_q}) + $signed({{2{step_q[31]}}, step_q});
		lev  = $signed({2'b00, level_q, 16'b0});
		hsel = hsum;
		vsel = v_q;
		if (lev > hsum) begin
			hsel = lev;
			vsel = '0;
		end
		if (hsel <= 34'sd0) begin
			hnew = '0;
			vnew = '0;
		end else if (hsel > $signed({2'b00, 32'hFFFF_FFFF})) begin
			hnew = 32'hFFFF_FFFF;
			vnew = vsel;
		end else begin
			hnew = hsel[31:0];
			vnew = vsel;
		end
	end

	assign mem_we    = (state_q == S_UPD);
	assign mem_wdata = {hnew, vnew};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wdata;
		end
		if (accept && in_range) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// 60*h = 64*h - 4*h
	assign h60     = {h_q, 6'b0} - {4'b0, h_q, 2'b0};
	assign lit_raw = h60[37:28];

	always_comb begin
		push_data.column      = band_q;
		push_data.frame_start = fs_q;
		if (lit_raw >= 10'(ROWS)) begin
			push_data.lit = LIT_W'(ROWS - 1);
		end else begin
			push_data.lit = lit_raw[LIT_W-1:0];
		end
	end
	assign push_valid = (state_q == S_LIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && in_range) begin
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_VEL;
				S_VEL: state_q <= S_POS;
				S_POS: state_q <= S_UPD;
				S_UPD: begin
					valid_q[addr_q] <= 1'b1;
					state_q         <= S_LIT;
				end
				S_LIT: begin
					if (push_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					band_q  <= band;
					addr_q  <= rd_addr;
					level_q <= level;
					dt_q    <= step_time;
					fs_q    <= frame_start;
				end
			end
			S_RD: begin
				h_q  <= valid_q[addr_q] ? rdata_s1[63:32] : 32'b0;
				v_q  <= valid_q[addr_q] ? rdata_s1[31:0] : 32'b0;
				dv_q <= dv_prod[31:16];
			end
			S_VEL: v_q <= vsat;
			S_POS: step_q <= vstep_prod[47:16];
			S_UPD: h_q <= hnew;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_ready |=> in_ready)
	else $error("front did not return to idle after handing off a column");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> valid_q[$past(addr_q)])
	else $error("band state written without its valid bit");

	assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (32'(push_data.lit) < 32'(ROWS)))
	else $error("lit count reaches the top row");

endmodule

// ----- rtl/core/sbfr_queue.sv -----
module sbfr_queue
	import sbfr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  col_job_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output col_job_t pop_data
);

	localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	col_job_t        slot_q [Q_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Q_DEPTH))
	else $error("queue count past depth");

endmodule

// ----- rtl/core/sbfr_back.sv -----
module sbfr_back
	import sbfr_pkg::*;
#(
	parameter int ROWS = ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  col_job_t         pop_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [COL_W-1:0] out_column,
	output logic [COL_W-1:0] out_row,
	output logic [PIX_W-1:0] out_hue,
	output logic [PIX_W-1:0] out_brightness,
	output logic             out_last
);

	localparam int CW = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic                active_q;
	logic [CW-1:0]       row_q;
	logic [LIT_W-1:0]    lit_q;
	logic [COL_W-1:0]    col_q;
	logic [HUE_W-1:0]    hue_q;
	logic                out_valid_q;
	logic [COL_W-1:0]    out_col_q;
	logic [COL_W-1:0]    out_row_q;
	logic [PIX_W-1:0]    out_hue_q;
	logic [PIX_W-1:0]    out_bri_q;
	logic                out_last_q;

	logic                emit;
	logic                lit_px;
	logic                top_row;
	logic [CW+COL_W-1:0] row_ext;

	assign pop_ready = !active_q;
	assign emit      = active_q && (!out_valid_q || out_ready);
	assign lit_px    = (LIT_W'(row_q) < lit_q);
	assign top_row   = (row_q == CW'(ROWS - 1));
	assign row_ext   = (CW + COL_W)'(row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			hue_q       <= '0;
			row_q       <= '0;
		end else begin
			if (pop_valid && pop_ready) begin
				active_q <= 1'b1;
				row_q    <= '0;
				if (pop_data.frame_start) begin
					hue_q <= '0;
				end
			end else if (emit) begin
				if (lit_px) begin
					hue_q <= hue_q + 1'b1;
				end
				if (top_row) begin
					active_q <= 1'b0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			lit_q <= pop_data.lit;
			col_q <= pop_data.column;
		end
		if (emit) begin
			out_col_q  <= col_q;
			out_row_q  <= row_ext[COL_W-1:0];
			out_hue_q  <= lit_px ? hue_mod(hue_q) : PIX_DARK;
			out_bri_q  <= lit_px ? PIX_FULL : PIX_DARK;
			out_last_q <= top_row;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_column     = out_col_q;
	assign out_row        = out_row_q;
	assign out_hue        = out_hue_q;
	assign out_brightness = out_bri_q;
	assign out_last       = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> (out_bri_q == PIX_DARK))
	else $error("top row lit");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_hue_q != 8'hFF))
	else $error("hue out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && pop_ready |-> !out_valid_q || !active_q)
	else $error("new column taken while one is still being drawn");

endmodule

// ----- rtl/core/spectrum_bar_falloff_render.sv -----
// Spectrum bar renderer with gravity falloff. Each input item names one band, its new
// level (4.12), the frame time step (0.16 s) and, in tuser, a frame-start flag that clears
// the hue counter. The band's stored height and velocity are advanced (velocity falls by
// fall_accel*dt, height moves by velocity*dt, a higher level snaps the bar up, the bar
// floors at zero) and one column of ROWS pixels comes out, bottom row first, with tlast
// on the top row. Rows below floor(60*height), capped at ROWS-1, are lit at full value
// with hue = running counter mod 255; all other rows are dark. Items whose band is not
// below BANDS are taken and dropped with no output and no state change. The emitter draws
// one pixel a cycle unless the output stalls, taking a new column after the top row; the
// band update walks read, velocity, position, update and hand-off for each item and runs
// ahead of the emitter through a 2-entry queue. fall_accel (reset 1) is written through
// the cfg channel, which is always ready; write it only while the block is idle.
module spectrum_bar_falloff_render
	import sbfr_pkg::*;
#(
	parameter int BANDS = BANDS_DEF,
	parameter int ROWS  = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,

	// config: fall_accel, 2^-28 height/s^2 units
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ACC_W-1:0]  cfg_data,

	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// [4:0] band, [20:5] level, [36:21] step_time, [39:37] zero
	input  logic [39:0]       s_axis_tdata,
	// [0] frame_start
	input  logic              s_axis_tuser,

	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [4:0] column, [9:5] row, [17:10] hue, [25:18] saturation,
	// [33:26] brightness, [39:34] zero
	output logic [39:0]       m_axis_tdata,
	output logic              m_axis_tlast
);

	logic [ACC_W-1:0] fall_accel_q;

	logic             push_valid;
	logic             push_ready;
	col_job_t         push_data;
	logic             pop_valid;
	logic             pop_ready;
	col_job_t         pop_data;

	logic [COL_W-1:0] px_column;
	logic [COL_W-1:0] px_row;
	logic [PIX_W-1:0] px_hue;
	logic [PIX_W-1:0] px_brightness;

	// single config register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_accel_q <= FALL_ACCEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			fall_accel_q <= cfg_data;
		end
	end

	// front: takes items, runs the band physics, queues {column, lit count, frame_start}
	sbfr_front #(
		.BANDS (BANDS),
		.ROWS  (ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.fall_accel  (fall_accel_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.band        (s_axis_tdata[4:0]),
		.level       (s_axis_tdata[20:5]),
		.step_time   (s_axis_tdata[36:21]),
		.frame_start (s_axis_tuser),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	sbfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: owns the hue counter and draws one pixel per cycle into the output register while the output is not stalled
	sbfr_back #(
		.ROWS (ROWS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_data       (pop_data),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_column     (px_column),
		.out_row        (px_row),
		.out_hue        (px_hue),
		.out_brightness (px_brightness),
		.out_last       (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, px_brightness, PIX_FULL, px_hue, px_row, px_column};

endmodule

// ----- tb/spectrum_bar_falloff_render_test.sv -----
// Testbench for spectrum_bar_falloff_render.
//
// Band items are queued by the stimulus process and pushed by a falling-edge driver; each
// accepted item is run through a behavioral copy of the bar physics (velocity falls by
// fall_accel*dt, height moves by velocity*dt, level snaps up, floor at zero) and the
// column of ROWS pixels it must produce is appended to the expected-pixel queue. A
// rising-edge monitor pops and compares every pixel field by field.
//
// Flow: reset-value accel with edge levels, then full accel with falloff and floor
// sequences, then several accel settings with random bursts mostly on a few bands, and
// last one long frame, opened by a frame start, with no idling, at high levels.
module spectrum_bar_falloff_render_test;
	import sbfr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BANDS = BANDS_DEF;
	localparam int ROWS  = ROWS_DEF;

	// settle time before a register write or the end check; covers the band update plus
	// the column queue
	localparam int SETTLE_CYCLES = 24;
	// ~500 items * 32 pixels, each behind the longest ready stall, taken about 5x over
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int END_WAIT    = 20_000;
	localparam int FRAME_ITEMS = 180;

	typedef struct {
		logic [COL_W-1:0]   band;
		logic [LEVEL_W-1:0] level;
		logic [DT_W-1:0]    dt;
		logic               fs;
	} band_item_t;

	typedef struct {
		logic [COL_W-1:0] column;
		logic [4:0]       row;
		logic [PIX_W-1:0] hue;
		logic [PIX_W-1:0] sat;
		logic [PIX_W-1:0] bright;
		logic             is_top;
	} pixel_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ACC_W-1:0]  cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	// [4:0] band, [20:5] level, [36:21] step_time, [39:37] zero
	logic [39:0]       s_axis_tdata = '0;
	// [0] frame_start
	logic              s_axis_tuser = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	// [4:0] column, [9:5] row, [17:10] hue, [25:18] saturation, [33:26] brightness
	logic [39:0]       m_axis_tdata;
	logic              m_axis_tlast;

	// stimulus and expectations
	band_item_t bands_to_send[$];
	pixel_t     pixels_due[$];

	// behavioral copy of the block state
	logic [ACC_W-1:0]  fall_accel_now;
	logic [31:0]       bar_height[BANDS];
	logic signed [31:0] bar_speed[BANDS];
	logic [HUE_W-1:0]  hue_count;

	// handshake bookkeeping and run statistics
	bit  idling = 1'b1;
	bit  item_taken = 1'b0;
	bit  hue_wrapped = 1'b0;
	int  send_gap = 0;
	int  stall_left = 0;
	int  errors = 0;
	int  items_taken = 0;
	int  pixels_checked = 0;
	int  lit_seen = 0;
	int  accel_writes = 0;
	longint cycles = 0;

	spectrum_bar_falloff_render #(
		.BANDS(BANDS),
		.ROWS (ROWS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int x;
		if (!idling) begin
			return 0;
		end
		x = $urandom_range(99);
		if (x < 55) begin
			return 0;
		end else if (x < 93) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(24, 8);
	endfunction

	// Advance one band and push the column it renders.
	task automatic render_band(input logic [COL_W-1:0] band, input logic [LEVEL_W-1:0] level,
			input logic [DT_W-1:0] dt, input logic fs);
		longint dtl, dv, v, h, lev, fall, lit;
		pixel_t p;
		dtl = longint'(dt);
		if (fs) begin
			hue_count = '0;
		end
		dv = (longint'(fall_accel_now) * dtl) >>> 16;
		v = longint'(bar_speed[band]) - dv;
		if (v < -64'sd2147483648) begin
			v = -64'sd2147483648;
		end
		// height step rounds toward minus infinity
		if (v >= 0) begin
			fall = (v * dtl) >>> 16;
		end else begin
			fall = -(((-v) * dtl + 65535) >>> 16);
		end
		h = longint'(bar_height[band]) + fall;
		lev = longint'(level) * 65536;
		if (lev > h) begin
			h = lev;
			v = 0;
		end
		if (h <= 0) begin
			h = 0;
			v = 0;
		end
		if (h > 64'sh0_FFFF_FFFF) begin
			h = 64'sh0_FFFF_FFFF;
		end
		bar_height[band] = h[31:0];
		bar_speed[band] = v[31:0];

		lit = (h * 60) >>> 28;
		if (lit >= ROWS) begin
			lit = ROWS - 1;
		end
		for (int r = 0; r < ROWS; r++) begin
			p.column = band;
			p.row = r[4:0];
			p.sat = PIX_FULL;
			p.is_top = (r == ROWS - 1);
			if (r < lit) begin
				p.hue = 8'(hue_count % 16'd255);
				p.bright = PIX_FULL;
				hue_count = hue_count + 16'd1;
				if (hue_count == '0) begin
					hue_wrapped = 1'b1;
				end
			end else begin
				p.hue = PIX_DARK;
				p.bright = PIX_DARK;
			end
			pixels_due.push_back(p);
		end
	endtask

	task automatic send(input int band, input int level, input int dt, input bit fs);
		band_item_t it;
		it.band = band[COL_W-1:0];
		it.level = level[LEVEL_W-1:0];
		it.dt = dt[DT_W-1:0];
		it.fs = fs;
		bands_to_send.push_back(it);
	endtask

	// Bursts on one band: a level kick, then mostly silence so the bar falls.
	// About a third of the bursts land on any band, the rest on a few hot bands.
	task automatic queue_bursts(input int count);
		int n, len, band, level, dt, x;
		n = 0;
		while (n < count) begin
			band = ($urandom_range(9) < 7) ? $urandom_range(3, 0) : $urandom_range(BANDS - 1, 0);
			len = $urandom_range(40, 1);
			for (int i = 0; i < len && n < count; i++) begin
				x = $urandom_range(99);
				if (i == 0) begin
					level = (x < 20) ? $urandom_range(16'hFFFF, 0) : $urandom_range(2300, 0);
				end else if (x < 70) begin
					level = 0;
				end else if (x < 85) begin
					level = $urandom_range(2300, 0);
				end else begin
					level = $urandom_range(16'hFFFF, 0);
				end
				x = $urandom_range(99);
				if (x < 50) begin
					dt = $urandom_range(16'hFFFF, 16'hC000);
				end else if (x < 75) begin
					dt = $urandom_range(16'hFFFF, 0);
				end else if (x < 90) begin
					dt = $urandom_range(255, 0);
				end else begin
					dt = $urandom_range(1, 0) ? 16'hFFFF : 0;
				end
				send(band, level, dt, $urandom_range(9) == 0);
				n++;
			end
		end
	endtask

	// Wait until every queued item is in and every expected pixel is out.
	task automatic settle();
		do begin
			@(posedge clk);
		end while (bands_to_send.size() != 0 || s_axis_tvalid || pixels_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fall_accel(input logic [ACC_W-1:0] value);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		fall_accel_now = value;
		accel_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Input side: present the next item once the current one is taken.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			render_band(s_axis_tdata[4:0], s_axis_tdata[20:5], s_axis_tdata[36:21],
				s_axis_tuser);
			items_taken++;
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		band_item_t nxt;
		if (arst_n) begin
			if (s_axis_tvalid && !item_taken) begin
				// still waiting for tready
			end else if (send_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap--;
			end else if (bands_to_send.size() != 0) begin
				nxt = bands_to_send.pop_front();
				s_axis_tdata <= {3'b000, nxt.dt, nxt.level, nxt.band};
				s_axis_tuser <= nxt.fs;
				s_axis_tvalid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			item_taken = 1'b0;

			// output backpressure, independent of the pixel stream
			if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// Output side: every pixel against the oldest expectation.
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			pixels_checked++;
			if (m_axis_tdata[33:26] == PIX_FULL) begin
				lit_seen++;
			end
			if (pixels_due.size() == 0) begin
				flag_error($sformatf("pixel with nothing expected: column %0d row %0d",
					m_axis_tdata[4:0], m_axis_tdata[9:5]));
			end else begin
				want = pixels_due.pop_front();
				if (m_axis_tdata[4:0] !== want.column) begin
					flag_error($sformatf("column %0d, want %0d", m_axis_tdata[4:0], want.column));
				end
				if (m_axis_tdata[9:5] !== want.row) begin
					flag_error($sformatf("column %0d: row %0d, want %0d", want.column,
						m_axis_tdata[9:5], want.row));
				end
				if (m_axis_tdata[17:10] !== want.hue) begin
					flag_error($sformatf("column %0d row %0d: hue %0d, want %0d", want.column,
						want.row, m_axis_tdata[17:10], want.hue));
				end
				if (m_axis_tdata[25:18] !== want.sat) begin
					flag_error($sformatf("column %0d row %0d: saturation %0d, want %0d",
						want.column, want.row, m_axis_tdata[25:18], want.sat));
				end
				if (m_axis_tdata[33:26] !== want.bright) begin
					flag_error($sformatf("column %0d row %0d: brightness %0d, want %0d",
						want.column, want.row, m_axis_tdata[33:26], want.bright));
				end
				if (m_axis_tlast !== want.is_top) begin
					flag_error($sformatf("column %0d row %0d: tlast %b, want %b", want.column,
						want.row, m_axis_tlast, want.is_top));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d pixels outstanding", cycles,
				pixels_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int waited;
		fall_accel_now = FALL_ACCEL_RST;
		for (int b = 0; b < BANDS; b++) begin
			bar_height[b] = '0;
			bar_speed[b] = '0;
		end
		hue_count = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset accel (1): bars only snap up, dv rounds to zero
		send(0, 0, 0, 1);               // all dark
		send(31, 16'hFFFF, 16'hFFFF, 0); // full level, lit count capped, top row dark
		send(31, 0, 16'hFFFF, 0);
		send(1, 68, 1, 0);              // just below one lit row
		send(1, 69, 1, 0);              // exactly one lit row
		send(2, 2116, 100, 0);          // 30 rows
		send(2, 2117, 100, 0);          // 31 rows
		send(3, 2185, 100, 0);          // 32 computed, capped
		send(4, 1000, 500, 1);          // frame start clears hue mid-stream
		send(21, 16'hAAAA, 16'h5555, 0);
		send(10, 16'h5555, 16'hAAAA, 1);

		// full accel: fast falloff and the floor at zero
		write_fall_accel(16'hFFFF);
		send(7, 1, 16'hFFFF, 0);
		repeat (3) send(7, 0, 16'hFFFF, 0);
		send(8, 2200, 0, 0);
		repeat (5) send(8, 0, 16'hFFFF, 0);
		send(8, 1500, 0, 0);            // zero time step: nothing moves
		send(8, 0, 16'hFFFF, 0);

		// random bursts over a spread of accel settings
		queue_bursts(70);
		write_fall_accel(16'h0000);
		queue_bursts(50);
		write_fall_accel(16'(($urandom_range(255, 1)) << 8));
		queue_bursts(60);
		write_fall_accel(16'(1));
		queue_bursts(40);
		write_fall_accel(16'($urandom_range(16'hFFFF, 16'h8000)));
		queue_bursts(80);

		// one long frame at high levels with the hue counter running on; no idling here
		write_fall_accel(16'($urandom_range(16'hFFFF, 0)));
		idling = 1'b0;
		send($urandom_range(BANDS - 1, 0), 16'hFFFF, $urandom_range(16'hFFFF, 0), 1);
		for (int i = 1; i < FRAME_ITEMS; i++) begin
			send($urandom_range(BANDS - 1, 0), $urandom_range(16'hFFFF, 16'h1000),
				$urandom_range(16'hFFFF, 0), 0);
		end

		// drain with a bound, then let the block sit quiet for a while
		waited = 0;
		while ((bands_to_send.size() != 0 || s_axis_tvalid || pixels_due.size() != 0)
				&& waited < END_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bands_to_send.size() != 0 || pixels_due.size() != 0) begin
			flag_error($sformatf("%0d items unsent, %0d pixels never seen at end",
				bands_to_send.size(), pixels_due.size()));
		end

		$display("Covered %0d band items and %0d pixels (%0d lit) over %0d fall_accel writes",
			items_taken, pixels_checked, lit_seen, accel_writes);
		$display("Hue counter wrapped: %s; mismatches: %0d", hue_wrapped ? "yes" : "no", errors);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- spectrum_bar_falloff_render.f -----
rtl/core/sbfr_pkg.sv
rtl/core/sbfr_front.sv
rtl/core/sbfr_queue.sv
rtl/core/sbfr_back.sv
rtl/core/spectrum_bar_falloff_render.sv
tb/spectrum_bar_falloff_render_test.sv
